// ----- src/fipbs_pkg.sv -----
// Shared types, constants and the binary64 round-and-pack function.
package fipbs_pkg;

  localparam logic [63:0] FP_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_QUIET    = 64'h0008_0000_0000_0000;
  localparam logic [63:0] FP_DEF_NAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0] FP_EXP_MAX  = 11'h7FF;
  localparam int          DIV_STEPS   = 58;
  localparam int          PP_STEPS    = 5;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_UNPACK_ACC,
    DP_UNPACK_SQ,
    DP_UNPACK_DIV,
    DP_NORM,
    DP_PP,
    DP_MUL_ROUND,
    DP_SHIFT_MAG,
    DP_DIV_STEP,
    DP_DIV_ROUND,
    DP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ_DEC,
    ST_MUNPACK,
    ST_DUNPACK,
    ST_NORM,
    ST_PP,
    ST_MROUND,
    ST_DSTEP,
    ST_DROUND,
    ST_OUT
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic mag_lsb;
    logic mag_last;
    logic neg;
    logic spec;
    logic normed;
    logic out_free;
  } dp_status_t;

  // The significand has its leading one at bit 109 and is worth sig / 2^109 * 2^(be - 1023).
  function automatic logic [63:0] round_pack(input logic sgn, input logic signed [13:0] be,
                                             input logic [109:0] sig, input logic stk);
    logic signed [13:0] shv;
    logic [6:0]         sh;
    logic [109:0]       s2;
    logic [109:0]       lost_mask;
    logic               sticky;
    logic [62:0]        field;
    logic               inc;
    logic [63:0]        res;
    shv       = 14'sd1 - be;
    sh        = '0;
    if (be <= 14'sd0) begin
      sh = (shv > 14'sd127) ? 7'd127 : shv[6:0];
    end
    s2        = sig >> sh;
    lost_mask = ~({110{1'b1}} << sh);
    sticky    = stk | (|(sig & lost_mask)) | (|s2[55:0]);
    field     = {(be > 14'sd0) ? be[10:0] : 11'd0, s2[108:57]};
    inc       = s2[56] & (sticky | s2[57]);
    res       = {sgn, field + {62'd0, inc}};
    if (be >= 14'sd2047) begin
      res = {sgn, FP_EXP_MAX, 52'd0};
    end
    return res;
  endfunction

endpackage

// ----- src/fipbs_ctrl.sv -----
// Controller state machine sequencing the square-and-multiply loop and the reciprocal.
module fipbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fipbs_pkg::dp_status_t status_i,
  output fipbs_pkg::dp_cmd_t    cmd_o
);
  import fipbs_pkg::*;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       op_sq_q, op_sq_d;
  logic       div_q, div_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      op_sq_q <= 1'b0;
      div_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_sq_q <= op_sq_d;
      div_q   <= div_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_sq_d = op_sq_q;
    div_d   = div_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.mag_zero) begin
          state_d = status_i.neg ? ST_DUNPACK : ST_OUT;
        end else if (status_i.mag_lsb) begin
          op_sq_d = 1'b0;
          state_d = ST_MUNPACK;
        end else begin
          state_d = ST_SQ_DEC;
        end
      end
      ST_SQ_DEC: begin
        if (status_i.mag_last) begin
          state_d = ST_CHECK;
        end else begin
          op_sq_d = 1'b1;
          state_d = ST_MUNPACK;
        end
      end
      ST_MUNPACK: begin
        div_d   = 1'b0;
        state_d = ST_NORM;
      end
      ST_DUNPACK: begin
        div_d   = 1'b1;
        state_d = ST_NORM;
      end
      ST_NORM: begin
        cnt_d = '0;
        if (status_i.spec) begin
          state_d = div_q ? ST_DROUND : ST_MROUND;
        end else if (status_i.normed) begin
          state_d = div_q ? ST_DSTEP : ST_PP;
        end
      end
      ST_PP: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(PP_STEPS - 1)) begin
          state_d = ST_MROUND;
        end
      end
      ST_MROUND: begin
        state_d = op_sq_q ? ST_CHECK : ST_SQ_DEC;
      end
      ST_DSTEP: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = ST_DROUND;
        end
      end
      ST_DROUND: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.op   = DP_NOP;
    cmd_o.step = cnt_q[2:0];
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
        end
      end
      ST_SQ_DEC: begin
        if (status_i.mag_last) begin
          cmd_o.op = DP_SHIFT_MAG;
        end
      end
      ST_MUNPACK: cmd_o.op = op_sq_q ? DP_UNPACK_SQ : DP_UNPACK_ACC;
      ST_DUNPACK: cmd_o.op = DP_UNPACK_DIV;
      ST_NORM: begin
        if (!status_i.spec && !status_i.normed) begin
          cmd_o.op = DP_NORM;
        end
      end
      ST_PP:     cmd_o.op = DP_PP;
      ST_MROUND: cmd_o.op = DP_MUL_ROUND;
      ST_DSTEP:  cmd_o.op = DP_DIV_STEP;
      ST_DROUND: cmd_o.op = DP_DIV_ROUND;
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_OUT;
        end
      end
      default: cmd_o.op = DP_NOP;
    endcase
  end

endmodule

// ----- src/fipbs_dp.sv -----
// Datapath: operand registers, shared binary64 multiplier, reciprocal divider, output register.
module fipbs_dp #(
  parameter int EXP_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fipbs_pkg::dp_cmd_t    cmd_i,
  output fipbs_pkg::dp_status_t status_o,
  input  logic [63:0]           base_bits_i,
  input  logic [EXP_WIDTH-1:0]  exponent_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           power_bits_o
);
  import fipbs_pkg::*;

  logic [63:0]          acc_q, sq_q, spec_val_q, out_q;
  logic [EXP_WIDTH-1:0] mag_q;
  logic                 neg_q, dst_sq_q, spec_q, sgn_q, out_valid_q;
  logic [52:0]          ma_q, mb_q;
  logic signed [12:0]   ea_q, eb_q;
  logic [53:0]          pp_q;
  logic [1:0]           pp_step_q;
  logic [105:0]         prod_q;
  logic [53:0]          rem_q;
  logic [57:0]          quo_q;

  logic [63:0]          opa, opb, spec_val;
  logic                 a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, spec, is_div;
  logic [26:0]          a_part, b_part;
  logic [105:0]         pp_shifted;
  logic signed [13:0]   be_mul, be_div;
  logic [109:0]         sig_mul, sig_div;
  logic                 rem_ge;

  assign is_div = (cmd_i.op == DP_UNPACK_DIV);
  assign opa    = (cmd_i.op == DP_UNPACK_SQ) ? sq_q : acc_q;
  assign opb    = is_div ? acc_q : sq_q;

  assign a_nan  = (opa[62:52] == FP_EXP_MAX) && (opa[51:0] != '0);
  assign a_inf  = (opa[62:52] == FP_EXP_MAX) && (opa[51:0] == '0);
  assign a_zero = (opa[62:0] == '0);
  assign b_nan  = (opb[62:52] == FP_EXP_MAX) && (opb[51:0] != '0);
  assign b_inf  = (opb[62:52] == FP_EXP_MAX) && (opb[51:0] == '0);
  assign b_zero = (opb[62:0] == '0);

  always_comb begin
    if (is_div) begin
      spec = b_nan | b_inf | b_zero;
      if (b_nan) begin
        spec_val = opb | FP_QUIET;
      end else if (b_inf) begin
        spec_val = {opb[63], 63'd0};
      end else begin
        spec_val = {opb[63], FP_EXP_MAX, 52'd0};
      end
    end else begin
      spec = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
      if (a_nan) begin
        spec_val = opa | FP_QUIET;
      end else if (b_nan) begin
        spec_val = opb | FP_QUIET;
      end else if ((a_inf & b_zero) | (a_zero & b_inf)) begin
        spec_val = FP_DEF_NAN;
      end else if (a_inf | b_inf) begin
        spec_val = {opa[63] ^ opb[63], FP_EXP_MAX, 52'd0};
      end else begin
        spec_val = {opa[63] ^ opb[63], 63'd0};
      end
    end
  end

  // Partial products in the order low*low, low*high, high*low, high*high.
  assign a_part = cmd_i.step[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
  assign b_part = cmd_i.step[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];

  always_comb begin
    case (pp_step_q)
      2'd0:    pp_shifted = {52'd0, pp_q};
      2'd3:    pp_shifted = {pp_q, 52'd0} << 2;
      default: pp_shifted = {25'd0, pp_q, 27'd0};
    endcase
  end

  assign be_mul  = 14'(ea_q) + 14'(eb_q) + 14'(prod_q[105]) + 14'sd1023;
  assign sig_mul = prod_q[105] ? {prod_q, 4'd0} : {prod_q[104:0], 5'd0};
  assign be_div  = 14'sd1023 - 14'(eb_q) - 14'(!quo_q[57]);
  assign sig_div = quo_q[57] ? {quo_q, 52'd0} : {quo_q[56:0], 53'd0};
  assign rem_ge  = (rem_q >= {1'b0, mb_q});

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        acc_q <= FP_ONE;
        sq_q  <= base_bits_i;
        neg_q <= exponent_i[EXP_WIDTH-1];
        mag_q <= exponent_i[EXP_WIDTH-1] ? (~exponent_i + 1'b1) : exponent_i;
      end
      DP_UNPACK_ACC, DP_UNPACK_SQ, DP_UNPACK_DIV: begin
        dst_sq_q   <= (cmd_i.op == DP_UNPACK_SQ);
        spec_q     <= spec;
        spec_val_q <= spec_val;
        sgn_q      <= is_div ? opb[63] : (opa[63] ^ opb[63]);
        ma_q       <= is_div ? 53'h10_0000_0000_0000 : {|opa[62:52], opa[51:0]};
        ea_q       <= (opa[62:52] == '0) ? -13'sd1022 : 13'(opa[62:52]) - 13'sd1023;
        mb_q       <= {|opb[62:52], opb[51:0]};
        eb_q       <= (opb[62:52] == '0) ? -13'sd1022 : 13'(opb[62:52]) - 13'sd1023;
        rem_q      <= 54'h10_0000_0000_0000;
        quo_q      <= '0;
      end
      DP_NORM: begin
        if (!ma_q[52]) begin
          ma_q <= ma_q << 1;
          ea_q <= ea_q - 13'sd1;
        end
        if (!mb_q[52]) begin
          mb_q <= mb_q << 1;
          eb_q <= eb_q - 13'sd1;
        end
      end
      DP_PP: begin
        pp_q      <= {27'd0, a_part} * {27'd0, b_part};
        pp_step_q <= cmd_i.step[1:0];
        prod_q    <= (cmd_i.step == 3'd0) ? '0 : prod_q + pp_shifted;
      end
      DP_MUL_ROUND: begin
        if (dst_sq_q) begin
          sq_q  <= spec_q ? spec_val_q : round_pack(sgn_q, be_mul, sig_mul, 1'b0);
          mag_q <= mag_q >> 1;
        end else begin
          acc_q <= spec_q ? spec_val_q : round_pack(sgn_q, be_mul, sig_mul, 1'b0);
        end
      end
      DP_SHIFT_MAG: mag_q <= mag_q >> 1;
      DP_DIV_STEP: begin
        rem_q <= (rem_ge ? rem_q - {1'b0, mb_q} : rem_q) << 1;
        quo_q <= {quo_q[56:0], rem_ge};
      end
      DP_DIV_ROUND: begin
        acc_q <= spec_q ? spec_val_q : round_pack(sgn_q, be_div, sig_div, rem_q != '0);
      end
      DP_OUT: out_q <= acc_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (cmd_i.op == DP_OUT) | (out_valid_q & ~out_ready_i);
    end
  end

  assign status_o.mag_zero = (mag_q == '0);
  assign status_o.mag_lsb  = mag_q[0];
  assign status_o.mag_last = ((mag_q >> 1) == '0);
  assign status_o.neg      = neg_q;
  assign status_o.spec     = spec_q;
  assign status_o.normed   = ma_q[52] & mb_q[52];
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign power_bits_o = out_q;

endmodule

// ----- src/float_int_power_by_squaring.sv -----
// Top level of the binary64 integer power unit.
//
// The input channel (in_valid_i / in_ready_o) carries a binary64 base and a signed
// exponent of EXP_WIDTH bits; the output channel (out_valid_o / out_ready_i) carries
// one binary64 result per item. An item is taken only while the controller is idle.
// The time from acceptance to a valid result grows with a multiply for each set
// magnitude bit and a squaring for each bit below the top one (one fewer squaring than the
// magnitude's bit length), plus the reciprocal when the exponent is negative; a
// zero exponent goes straight to the output. Each multiply uses one shared 27x27
// multiplier over four partial products and then rounds; the reciprocal is a
// restoring divider producing one quotient bit per cycle. Subnormal operands are
// normalised first, one leading zero at a time, and a special operand skips the
// partial products or the divider steps. The next item can be accepted in the
// cycle in which the result appears.
// Reset clears the controller and the output valid flag; the block is then idle.
// A finished result waits in the output register while a new item may be accepted;
// the next result is only written once the receiver has taken the previous one.
module float_int_power_by_squaring #(
  parameter int EXP_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [63:0]          base_bits_i,
  input  logic [EXP_WIDTH-1:0] exponent_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          power_bits_o
);
  import fipbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fipbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fipbs_dp #(
    .EXP_WIDTH (EXP_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .base_bits_i  (base_bits_i),
    .exponent_i   (exponent_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .power_bits_o (power_bits_o)
  );

  // Once an item is taken, the controller is busy in the cycle after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A result is never written over one that the receiver has not yet taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_OUT) |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // Normalisation only runs on operands that need the arithmetic path.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_NORM) |-> !status.spec)
    else $error("normalising a special operand");

endmodule
